>>> design/fcd_pkg.sv
// fcd_pkg: shared types and constants for the flux cell time decoder
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package fcd_pkg;

   // default width of the per-revolution transition counter
   localparam int unsigned COUNT_BITS_DEFAULT = 24;
   // default depth of the queue between front and back
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // fixed field widths
   localparam int unsigned TIME_W = 32;
   localparam int unsigned CNT_W = 24;
   localparam int unsigned CAP_W = 24;

   // a zero cell stands for a full 16-bit wrap of the cell timer
   localparam logic [TIME_W-1:0] WRAP_ADD = 32'h0001_0000;
   localparam logic [CAP_W-1:0] CAP_RESET = 24'd65536;

   // result kinds
   localparam logic KIND_TRANSITION = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // status codes
   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [1:0] STATUS_CAPACITY = 2'd2;

   // work description handed from front to back: at most two results
   typedef struct packed {
      logic [TIME_W-1:0] time_value;
      logic [CNT_W-1:0] transition_count;
      logic emit_transition;
      logic emit_summary;
      logic [1:0] status;
   } fcd_desc_type;

   // queue status seen by both sides
   typedef struct packed {
      logic not_empty;
      logic full;
   } fcd_queue_status_type;

endpackage

`default_nettype wire

>>> design/fcd_front.sv
// fcd_front: accepts bytes, pairs them into cells, keeps time and count
// depends on fcd_pkg
`timescale 1ns / 1ps
`default_nettype none

module fcd_front #(
   parameter int unsigned COUNT_BITS = fcd_pkg::COUNT_BITS_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [7:0] req_data_byte,
   input wire logic req_first_byte,
   input wire logic req_last_byte,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [fcd_pkg::CAP_W-1:0] csr_transition_capacity,
   input wire fcd_pkg::fcd_queue_status_type q_status,
   output logic push,
   output fcd_pkg::fcd_desc_type push_desc
);

   localparam int unsigned LIM_BITS = (COUNT_BITS < fcd_pkg::CAP_W) ? COUNT_BITS
                                                                     : fcd_pkg::CAP_W;
   localparam logic [fcd_pkg::CAP_W-1:0] CAP_LIMIT =
      fcd_pkg::CAP_W'((64'd1 << LIM_BITS) - 64'd1);

   logic [fcd_pkg::CAP_W-1:0] cap_ff;
   logic [fcd_pkg::TIME_W-1:0] time_ff, time_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [7:0] hold_ff, hold_in;
   logic phase_ff, phase_in;
   logic halted_ff, halted_in;

   logic accept;
   logic [fcd_pkg::CAP_W-1:0] cap_eff;
   logic [fcd_pkg::TIME_W-1:0] t0;
   logic [COUNT_BITS-1:0] c0;
   logic ph0, h0;
   logic [15:0] cell_word;
   logic [fcd_pkg::TIME_W-1:0] add;
   logic [fcd_pkg::TIME_W:0] sum;

   assign csr_ready = 1'b1;
   assign req_stall = q_status.full;
   assign accept = req_valid & ~req_stall;
   assign cap_eff = (cap_ff > CAP_LIMIT) ? CAP_LIMIT : cap_ff;

   always_comb begin
      // first byte clears the revolution before the byte is used
      t0 = req_first_byte ? '0 : time_ff;
      c0 = req_first_byte ? '0 : count_ff;
      ph0 = req_first_byte ? 1'b0 : phase_ff;
      h0 = req_first_byte ? 1'b0 : halted_ff;
      cell_word = {hold_ff, req_data_byte};
      add = (cell_word != 16'd0) ? {16'd0, cell_word} : fcd_pkg::WRAP_ADD;
      sum = {1'b0, t0} + {1'b0, add};

      time_in = t0;
      count_in = c0;
      hold_in = hold_ff;
      phase_in = ph0;
      halted_in = h0;
      push_desc.time_value = t0;
      push_desc.transition_count = fcd_pkg::CNT_W'(c0);
      push_desc.emit_transition = 1'b0;
      push_desc.emit_summary = 1'b0;
      push_desc.status = fcd_pkg::STATUS_OK;

      if (!h0) begin
         if (!ph0) begin
            if (!req_last_byte) begin
               hold_in = req_data_byte;
               phase_in = 1'b1;
            end else begin
               // odd trailing byte dropped, summary only
               push_desc.emit_summary = 1'b1;
            end
         end else begin
            phase_in = 1'b0;
            if (sum[fcd_pkg::TIME_W]) begin
               halted_in = 1'b1;
               push_desc.emit_summary = 1'b1;
               push_desc.status = fcd_pkg::STATUS_OVERFLOW;
            end else begin
               time_in = sum[fcd_pkg::TIME_W-1:0];
               push_desc.time_value = sum[fcd_pkg::TIME_W-1:0];
               if (cell_word != 16'd0 && 32'(c0) >= 32'(cap_eff)) begin
                  halted_in = 1'b1;
                  push_desc.emit_summary = 1'b1;
                  push_desc.status = fcd_pkg::STATUS_CAPACITY;
               end else begin
                  if (cell_word != 16'd0) begin
                     count_in = c0 + COUNT_BITS'(1);
                     push_desc.transition_count = fcd_pkg::CNT_W'(c0 + COUNT_BITS'(1));
                     push_desc.emit_transition = 1'b1;
                  end
                  if (req_last_byte) begin
                     push_desc.emit_summary = 1'b1;
                  end
               end
            end
         end
      end
   end

   assign push = accept & (push_desc.emit_transition | push_desc.emit_summary);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= fcd_pkg::CAP_RESET;
         time_ff <= '0;
         count_ff <= '0;
         hold_ff <= '0;
         phase_ff <= 1'b0;
         halted_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_transition_capacity;
         end
         if (accept) begin
            time_ff <= time_in;
            count_ff <= count_in;
            hold_ff <= hold_in;
            phase_ff <= phase_in;
            halted_ff <= halted_in;
         end
      end
   end

endmodule

`default_nettype wire

>>> design/fcd_queue.sv
// fcd_queue: short first-in first-out queue of work descriptions
// depends on fcd_pkg
`timescale 1ns / 1ps
`default_nettype none

module fcd_queue #(
   parameter int unsigned DEPTH = fcd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   input wire fcd_pkg::fcd_desc_type push_desc,
   input wire logic pop,
   output fcd_pkg::fcd_desc_type head_desc,
   output fcd_pkg::fcd_queue_status_type q_status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned FILL_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

   fcd_pkg::fcd_desc_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FILL_W-1:0] fill_ff;
   logic do_push, do_pop;

   assign q_status.not_empty = (fill_ff != '0);
   assign q_status.full = (fill_ff == FULL_FILL);
   assign do_push = push & ~q_status.full;
   assign do_pop = pop & q_status.not_empty;
   assign head_desc = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + FILL_W'(1);
         end else if (!do_push && do_pop) begin
            fill_ff <= fill_ff - FILL_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

>>> design/fcd_back.sv
// fcd_back: turns queued descriptions into result words in an output register
// depends on fcd_pkg
`timescale 1ns / 1ps
`default_nettype none

module fcd_back (
   input wire logic clock,
   input wire logic reset,
   input wire fcd_pkg::fcd_desc_type head_desc,
   input wire fcd_pkg::fcd_queue_status_type q_status,
   output logic pop,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic rsp_result_kind,
   output logic [fcd_pkg::TIME_W-1:0] rsp_time_value,
   output logic [fcd_pkg::CNT_W-1:0] rsp_transition_count,
   output logic [1:0] rsp_status,
   output logic rsp_run_end
);

   logic valid_ff, valid_in;
   logic pend_ff, pend_in;
   logic kind_ff, kind_in;
   logic [fcd_pkg::TIME_W-1:0] time_ff, time_in;
   logic [fcd_pkg::CNT_W-1:0] count_ff, count_in;
   logic [1:0] status_ff, status_in;
   logic run_end_ff, run_end_in;
   logic load;

   assign load = ~valid_ff | ~rsp_stall;
   assign pop = load & ~pend_ff & q_status.not_empty;

   always_comb begin
      valid_in = valid_ff;
      pend_in = pend_ff;
      kind_in = kind_ff;
      time_in = time_ff;
      count_in = count_ff;
      status_in = status_ff;
      run_end_in = run_end_ff;
      if (load) begin
         if (pend_ff) begin
            // summary after a transition: same time and count
            valid_in = 1'b1;
            pend_in = 1'b0;
            kind_in = fcd_pkg::KIND_SUMMARY;
            status_in = fcd_pkg::STATUS_OK;
            run_end_in = 1'b1;
         end else if (q_status.not_empty) begin
            valid_in = 1'b1;
            time_in = head_desc.time_value;
            count_in = head_desc.transition_count;
            if (head_desc.emit_transition) begin
               kind_in = fcd_pkg::KIND_TRANSITION;
               status_in = fcd_pkg::STATUS_OK;
               run_end_in = ~head_desc.emit_summary;
               pend_in = head_desc.emit_summary;
            end else begin
               kind_in = fcd_pkg::KIND_SUMMARY;
               status_in = head_desc.status;
               run_end_in = 1'b1;
               pend_in = 1'b0;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      time_ff <= time_in;
      count_ff <= count_in;
      status_ff <= status_in;
      run_end_ff <= run_end_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_time_value = time_ff;
   assign rsp_transition_count = count_ff;
   assign rsp_status = status_ff;
   assign rsp_run_end = run_end_ff;

endmodule

`default_nettype wire

>>> design/flux_cell_time_decoder.sv
// flux_cell_time_decoder: top level, front classifier, queue and result back end
// depends on fcd_pkg, fcd_front, fcd_queue, fcd_back
`timescale 1ns / 1ps
`default_nettype none

//  channel | direction | handshake              | word
//  req_    | in        | req_valid / req_stall  | data byte, first and last flags
//  rsp_    | out       | rsp_valid / rsp_stall  | kind, time, count, status, run end
//  csr_    | in        | csr_valid / csr_ready  | transition capacity (24 bits)
//
//  one byte accepted per cycle while the queue is not full (req_stall low)
//  each result passes through the queue and then the output register
//  a byte ending in both a transition and a summary holds the output for two result words;
//  the queue between front and back absorbs that and output stalls
//  req_stall rises only when the queue is full
//  synchronous reset clears time, count, phase, halt, queue and output valid, capacity to 65536

module flux_cell_time_decoder #(
   parameter int unsigned COUNT_BITS = fcd_pkg::COUNT_BITS_DEFAULT,
   parameter int unsigned QUEUE_DEPTH = fcd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   // byte input
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [7:0] req_data_byte,
   input wire logic req_first_byte,
   input wire logic req_last_byte,
   // capacity register write
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [fcd_pkg::CAP_W-1:0] csr_transition_capacity,
   // results
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic rsp_result_kind,
   output logic [fcd_pkg::TIME_W-1:0] rsp_time_value,
   output logic [fcd_pkg::CNT_W-1:0] rsp_transition_count,
   output logic [1:0] rsp_status,
   output logic rsp_run_end
);

   // front to queue
   logic push;
   fcd_pkg::fcd_desc_type push_desc;
   // queue to back
   fcd_pkg::fcd_desc_type head_desc;
   fcd_pkg::fcd_queue_status_type q_status;
   logic pop;

   // pairs bytes into cells, tracks time, count and halt, holds capacity
   fcd_front #(
      .COUNT_BITS(COUNT_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_first_byte(req_first_byte),
      .req_last_byte(req_last_byte),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_transition_capacity(csr_transition_capacity),
      .q_status(q_status),
      .push(push),
      .push_desc(push_desc)
   );

   // only bytes that produce results enter the queue
   fcd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_desc(push_desc),
      .pop(pop),
      .head_desc(head_desc),
      .q_status(q_status)
   );

   // splits each description into one or two result words
   fcd_back u_back (
      .clock(clock),
      .reset(reset),
      .head_desc(head_desc),
      .q_status(q_status),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind),
      .rsp_time_value(rsp_time_value),
      .rsp_transition_count(rsp_transition_count),
      .rsp_status(rsp_status),
      .rsp_run_end(rsp_run_end)
   );

endmodule

`default_nettype wire
